/* sv/text_console_writer_defines.svh */
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

`ifndef ASSERT_OFF
`define TCW_ASSERT(name, ck, rs, prop) \
  name: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("text console writer assertion failed");
`define TCW_NEVER(name, ck, rs, cond) `TCW_ASSERT(name, ck, rs, !(cond))
`else
`define TCW_ASSERT(name, ck, rs, prop)
`define TCW_NEVER(name, ck, rs, cond)
`endif

`endif

/* sv/tcw_pkg.sv */
// Types and constants for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int DEF_NUM_COLUMNS = 80;
  localparam int DEF_NUM_ROWS    = 25;
  localparam int DEF_TAB_CELLS   = 4;

  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int MODE_W    = 2;
  localparam int INDEX_W   = 11;
  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;

  localparam logic [COLOR_W-1:0] RESET_COLOR    = 8'd15;
  localparam logic [CHAR_W-1:0]  CODE_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0]  CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0]  CODE_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0]  CHAR_BLANK     = 8'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
  } item_t;

  typedef struct packed {
    logic [OUT_COL_W-1:0] cursor_column;
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [CHAR_W-1:0]    cell_char;
    logic [COLOR_W-1:0]   cell_color;
  } result_t;

  typedef struct packed {
    logic load;
    logic step;
  } sweep_ctl_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_INIT_CLR,
    ST_IDLE,
    ST_START,
    ST_LINE_BLANK,
    ST_ADV,
    ST_COPY,
    ST_DRAIN,
    ST_SCROLL_BLANK,
    ST_CLR,
    ST_READ_WAIT,
    ST_FIN
  } state_t;

endpackage

/* sv/tcw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/tcw_sweep.sv */
// Shared address sweep unit: one incrementer and one end compare.
`timescale 1ns / 1ps

module tcw_sweep
  import tcw_pkg::*;
#(
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  sweep_ctl_t    ctl,
  input  logic [AW-1:0] first,
  input  logic [AW-1:0] last,
  output logic [AW-1:0] addr,
  output logic          done
);

  logic [AW-1:0] last_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr      <= '0;
      last_addr <= '0;
    end else if (ctl.load) begin
      addr      <= first;
      last_addr <= last;
    end else if (ctl.step) begin
      addr <= addr + AW'(1);
    end
  end

  // The sweep ends on the cycle that handles the last address.
  assign done = (addr == last_addr);

endmodule

/* sv/text_console_writer.sv */
// Top level of the text console writer: sequencer, cursor and cell store.
// A character, backspace or read makes one store access before its result loads; a backspace
// at column zero, an unused mode or a read past the grid loads its result without one.
// Newline and tab blank cells first; a scroll moves the rows up and blanks the last one;
// a clear blanks every cell. The next item can be taken in the cycle after a result loads.
// Reset: synchronous; a clearing pass blanks the store in color 15 first.
`timescale 1ns / 1ps

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int NUM_COLUMNS = DEF_NUM_COLUMNS,
  parameter int NUM_ROWS    = DEF_NUM_ROWS,
  parameter int TAB_CELLS   = DEF_TAB_CELLS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [COLOR_W-1:0] cfg_write_data,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result
);

`include "text_console_writer_defines.svh"

  localparam int CELL_COUNT = NUM_COLUMNS * NUM_ROWS;
  localparam int AW = $clog2(CELL_COUNT);
  localparam int CW = $clog2(NUM_COLUMNS);
  localparam int RW = $clog2(NUM_ROWS);
  // Wide enough for the column plus a full tab before wrapping.
  localparam int SW = $clog2(NUM_COLUMNS + TAB_CELLS + 1);
  localparam int DW = CHAR_W + COLOR_W;

  localparam logic [AW-1:0] LAST_CELL     = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'(CELL_COUNT - NUM_COLUMNS);
  localparam logic [AW-1:0] COLS_A        = AW'(NUM_COLUMNS);
  localparam logic [AW-1:0] ROW_END_OFS   = AW'(NUM_COLUMNS - 1);
  localparam logic [AW-1:0] TAB_END_OFS   = AW'(TAB_CELLS - 1);
  localparam logic [RW-1:0] LAST_ROW      = RW'(NUM_ROWS - 1);
  localparam logic [SW-1:0] COLS_S        = SW'(NUM_COLUMNS);
  localparam logic [SW-1:0] TAB_S         = SW'(TAB_CELLS);

  state_t state, state_next;

  logic [COLOR_W-1:0] text_color;
  item_t              item_q;
  logic [CW-1:0]      col;
  logic [RW-1:0]      row;
  // row_base always equals row * NUM_COLUMNS, kept up by adds.
  logic [AW-1:0]      row_base;
  logic [AW-1:0]      wr_ptr;
  logic               copy_pend;
  logic [CHAR_W-1:0]  cell_char_q;
  logic [COLOR_W-1:0] cell_color_q;

  // Cell store port.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  // Sweep unit.
  sweep_ctl_t    sw_ctl;
  logic [AW-1:0] sw_first, sw_last, sw_addr;
  logic          sw_done;

  // Strobes from the sequencer to the datapath registers.
  logic cur_adv, cur_home, cap_cell, load_result;

  // Cursor arithmetic.
  logic [AW-1:0] base;
  logic [AW-1:0] row_end;
  logic [AW-1:0] tab_last;
  logic [SW-1:0] col_plus_tab;
  logic [SW-1:0] col_adv;
  logic          row_inc;
  logic          scroll_need;
  logic          in_range;
  logic [DW-1:0] blank_word;

  assign base         = row_base + AW'(col);
  assign row_end      = row_base + ROW_END_OFS;
  assign col_plus_tab = SW'(col) + TAB_S;
  // A tab blanks up to the line end when it would run past it.
  assign tab_last     = (col_plus_tab > COLS_S) ? row_end : (base + TAB_END_OFS);
  assign in_range     = (32'(item_q.cell_index) < 32'(CELL_COUNT));
  assign blank_word   = {text_color, CHAR_BLANK};

  // Column the put leaves behind, after wrapping, and whether the row moves on.
  always_comb begin
    col_adv = SW'(col) + SW'(1);
    row_inc = 1'b0;
    priority if (item_q.char_code == CODE_NEWLINE) begin
      col_adv = '0;
      row_inc = 1'b1;
    end else if (item_q.char_code == CODE_BACKSPACE) begin
      col_adv = SW'(col) - SW'(1);
    end else if (item_q.char_code == CODE_TAB) begin
      col_adv = col_plus_tab;
    end else begin
      col_adv = SW'(col) + SW'(1);
    end
    if (col_adv >= COLS_S) begin
      col_adv = '0;
      row_inc = 1'b1;
    end
  end

  assign scroll_need = row_inc && (row == LAST_ROW);

  tcw_sweep #(
    .AW(AW)
  ) u_sweep (
    .clk  (clk),
    .rst  (rst),
    .ctl  (sw_ctl),
    .first(sw_first),
    .last (sw_last),
    .addr (sw_addr),
    .done (sw_done)
  );

  tcw_ram #(
    .WIDTH(DW),
    .DEPTH(CELL_COUNT)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, store port, sweep control and strobes.
  always_comb begin
    state_next  = state;
    ram_we      = 1'b0;
    ram_waddr   = sw_addr;
    ram_wdata   = blank_word;
    ram_re      = 1'b0;
    ram_raddr   = sw_addr;
    sw_ctl      = '0;
    sw_first    = '0;
    sw_last     = LAST_CELL;
    cur_adv     = 1'b0;
    cur_home    = 1'b0;
    cap_cell    = 1'b0;
    load_result = 1'b0;

    unique case (state)
      ST_INIT: begin
        sw_ctl.load = 1'b1;
        state_next  = ST_INIT_CLR;
      end
      ST_INIT_CLR: begin
        // The power-up clear always uses the reset color.
        ram_we      = 1'b1;
        ram_wdata   = {RESET_COLOR, CHAR_BLANK};
        sw_ctl.step = 1'b1;
        if (sw_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        unique case (item_q.mode)
          MODE_PUT: begin
            priority if (item_q.char_code == CODE_NEWLINE) begin
              sw_ctl.load = 1'b1;
              sw_first    = base;
              sw_last     = row_end;
              state_next  = ST_LINE_BLANK;
            end else if (item_q.char_code == CODE_TAB) begin
              sw_ctl.load = 1'b1;
              sw_first    = base;
              sw_last     = tab_last;
              state_next  = ST_LINE_BLANK;
            end else if (item_q.char_code == CODE_BACKSPACE) begin
              if (col == '0) begin
                state_next = ST_FIN;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = base - AW'(1);
                state_next = ST_ADV;
              end
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = base;
              ram_wdata  = {text_color, item_q.char_code};
              state_next = ST_ADV;
            end
          end
          MODE_READ: begin
            if (in_range) begin
              ram_re     = 1'b1;
              ram_raddr  = AW'(item_q.cell_index);
              state_next = ST_READ_WAIT;
            end else begin
              state_next = ST_FIN;
            end
          end
          MODE_CLEAR: begin
            sw_ctl.load = 1'b1;
            cur_home    = 1'b1;
            state_next  = ST_CLR;
          end
          default: begin
            state_next = ST_FIN;
          end
        endcase
      end
      ST_LINE_BLANK: begin
        ram_we      = 1'b1;
        sw_ctl.step = 1'b1;
        if (sw_done) begin
          state_next = ST_ADV;
        end
      end
      ST_ADV: begin
        cur_adv = 1'b1;
        if (scroll_need) begin
          sw_ctl.load = 1'b1;
          sw_first    = COLS_A;
          state_next  = ST_COPY;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_COPY: begin
        // Read one row ahead; the word lands in the next cycle's write.
        ram_re      = 1'b1;
        ram_we      = copy_pend;
        ram_waddr   = wr_ptr;
        ram_wdata   = ram_rdata;
        sw_ctl.step = 1'b1;
        if (sw_done) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        ram_we      = 1'b1;
        ram_waddr   = wr_ptr;
        ram_wdata   = ram_rdata;
        sw_ctl.load = 1'b1;
        sw_first    = LAST_ROW_BASE;
        state_next  = ST_SCROLL_BLANK;
      end
      ST_SCROLL_BLANK, ST_CLR: begin
        ram_we      = 1'b1;
        sw_ctl.step = 1'b1;
        if (sw_done) begin
          state_next = ST_FIN;
        end
      end
      ST_READ_WAIT: begin
        cap_cell   = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!result_valid || result_ready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  assign item_ready = (state == ST_IDLE);

  // Color register and cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
      col        <= '0;
      row        <= '0;
      row_base   <= '0;
    end else begin
      if (cfg_write_en) begin
        text_color <= cfg_write_data;
      end
      if (cur_home) begin
        col      <= '0;
        row      <= '0;
        row_base <= '0;
      end else if (cur_adv) begin
        col <= CW'(col_adv);
        // On the last row a row step becomes a scroll and the cursor row stays put.
        if (row_inc && !scroll_need) begin
          row      <= row + RW'(1);
          row_base <= row_base + COLS_A;
        end
      end
    end
  end

  // Copy pointer for scrolling: each write goes one row above the address read in the cycle before.
  always_ff @(posedge clk) begin
    if (rst) begin
      copy_pend <= 1'b0;
      wr_ptr    <= '0;
    end else begin
      copy_pend <= (state == ST_COPY);
      if (state != ST_COPY) begin
        wr_ptr <= '0;
      end else if (copy_pend) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
    end
  end

  // Captured item and read cell; zero unless a read hits the store.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q       <= item;
      cell_char_q  <= '0;
      cell_color_q <= '0;
    end else if (cap_cell) begin
      cell_char_q  <= ram_rdata[CHAR_W-1:0];
      cell_color_q <= ram_rdata[DW-1:CHAR_W];
    end
  end

  // Output register: a finished item waits here while the next one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.cursor_column <= OUT_COL_W'(col);
      result.cursor_row    <= OUT_ROW_W'(row);
      result.cell_char     <= cell_char_q;
      result.cell_color    <= cell_color_q;
    end
  end

  `TCW_ASSERT(a_busy_after_accept, clk, rst, (item_valid && item_ready) |=> !item_ready)
  `TCW_NEVER(a_row_in_range, clk, rst, row > LAST_ROW)
  `TCW_NEVER(a_no_write_when_idle, clk, rst, ram_we && (state == ST_IDLE))
  `TCW_ASSERT(a_copy_write_after_read, clk, rst, (ram_we && (state == ST_COPY)) |-> $past(ram_re))
  `TCW_ASSERT(a_result_from_fin, clk, rst, $rose(result_valid) |-> $past(state == ST_FIN))

endmodule

/* bench/text_console_writer_checker.sv */
// Checker for the text console writer: keeps its own console and compares every reply.
`timescale 1ns / 1ps

module text_console_writer_checker
  import tcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [COLOR_W-1:0] cfg_write_data,
  input  logic               item_valid,
  input  logic               item_ready,
  input  item_t              item,
  input  logic               result_valid,
  input  logic               result_ready,
  input  result_t            result,
  output int                 mismatch_count,
  output int                 replies_due
);

  localparam int COLS      = DEF_NUM_COLUMNS;
  localparam int ROWS      = DEF_NUM_ROWS;
  localparam int TABS      = DEF_TAB_CELLS;
  localparam int CELLS     = COLS * ROWS;
  localparam int ENTRY_W   = COLOR_W + CHAR_W;
  localparam int PRINT_CAP = 100;

  // Each entry holds the attribute in the high byte and the character in the low byte.
  logic [ENTRY_W-1:0] grid [CELLS];
  logic [COLOR_W-1:0] text_color;
  int                 cur_col;
  int                 cur_row;
  result_t            console_replies [$];

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic clear_grid();
    for (int i = 0; i < CELLS; i++) grid[i] = {text_color, CHAR_BLANK};
    cur_col = 0;
    cur_row = 0;
  endtask

  task automatic scroll_grid();
    for (int i = 0; i < CELLS - COLS; i++) grid[i] = grid[i + COLS];
    for (int i = CELLS - COLS; i < CELLS; i++) grid[i] = {text_color, CHAR_BLANK};
    cur_row = ROWS - 1;
  endtask

  task automatic put_character(input logic [CHAR_W-1:0] ch);
    int base;
    base = cur_row * COLS + cur_col;
    case (ch)
      CODE_NEWLINE: begin
        for (int i = cur_col; i < COLS; i++) grid[cur_row * COLS + i] = {text_color, CHAR_BLANK};
        cur_col = 0;
        cur_row++;
      end
      CODE_BACKSPACE: begin
        // Nothing at all happens at the start of a line.
        if (cur_col == 0) return;
        grid[base - 1] = {text_color, CHAR_BLANK};
        cur_col--;
      end
      CODE_TAB: begin
        for (int i = 0; i < TABS && cur_col + i < COLS; i++)
          grid[base + i] = {text_color, CHAR_BLANK};
        cur_col += TABS;
      end
      default: begin
        grid[base] = {text_color, ch};
        cur_col++;
      end
    endcase
    if (cur_col >= COLS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) scroll_grid();
  endtask

  task automatic run_console_item(input item_t it, output result_t reply);
    reply = '0;
    case (it.mode)
      MODE_PUT: begin
        put_character(it.char_code);
      end
      MODE_READ: begin
        if (it.cell_index < CELLS) begin
          reply.cell_char  = grid[it.cell_index][CHAR_W-1:0];
          reply.cell_color = grid[it.cell_index][ENTRY_W-1:CHAR_W];
        end
      end
      MODE_CLEAR: begin
        clear_grid();
      end
      default: begin
      end
    endcase
    reply.cursor_column = cur_col[OUT_COL_W-1:0];
    reply.cursor_row    = cur_row[OUT_ROW_W-1:0];
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t fresh;
    if (rst) begin
      text_color = RESET_COLOR;
      clear_grid();
      console_replies.delete();
    end else begin
      // A reply never belongs to the item taken at the same edge, so compare first.
      if (result_valid && result_ready) begin
        if (console_replies.size() == 0) begin
          report_mismatch("reply with no item waiting for it");
        end else begin
          want = console_replies.pop_front();
          if (result.cursor_column !== want.cursor_column)
            report_mismatch($sformatf("cursor column %0d, predicted %0d",
                                      result.cursor_column, want.cursor_column));
          if (result.cursor_row !== want.cursor_row)
            report_mismatch($sformatf("cursor row %0d, predicted %0d",
                                      result.cursor_row, want.cursor_row));
          if (result.cell_char !== want.cell_char)
            report_mismatch($sformatf("cell char %0d, predicted %0d",
                                      result.cell_char, want.cell_char));
          if (result.cell_color !== want.cell_color)
            report_mismatch($sformatf("cell color %0d, predicted %0d",
                                      result.cell_color, want.cell_color));
        end
      end
      if (cfg_write_en) text_color = cfg_write_data;
      if (item_valid && item_ready) begin
        run_console_item(item, fresh);
        console_replies.push_back(fresh);
      end
    end
    replies_due = console_replies.size();
  end

endmodule

/* bench/text_console_writer_tb.sv */
// Testbench top for the text console writer: stimulus, idling on both sides and the verdict.
`timescale 1ns / 1ps

module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int COLS         = DEF_NUM_COLUMNS;
  localparam int CELLS        = COLS * DEF_NUM_ROWS;
  localparam int RANDOM_ITEMS = 1250;
  localparam int PHASES       = 4;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PAUSE   = 8;

  // The slowest correct run has every item scroll (a copy of the whole grid plus a line of
  // blanking), the sender's longest gap and the receiver's longest stall on every item,
  // the clearing pass after reset and the one long hold. The limit is set above what
  // such a run needs for this item count.
  localparam int CYCLE_LIMIT  = 10_000_000;

  // The one mode value the block does not define; it must leave everything alone.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               cfg_write_en   = 1'b0;
  logic [COLOR_W-1:0] cfg_write_data = '0;
  logic               item_valid     = 1'b0;
  logic               item_ready;
  item_t              item           = '0;
  logic               result_valid;
  logic               result_ready   = 1'b0;
  result_t            result;

  int mismatch_count;
  int replies_due;
  int cycle_count   = 0;
  bit hold_results  = 1'b0;
  bit sender_calm   = 1'b0;

  always #5 clk = ~clk;

  text_console_writer uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result)
  );

  // The checker sees exactly what the block sees and owns all of the comparison.
  text_console_writer_checker console_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result),
    .mismatch_count(mismatch_count),
    .replies_due   (replies_due)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic item_t make_item(input logic [MODE_W-1:0] mode,
                                      input logic [CHAR_W-1:0] ch,
                                      input logic [INDEX_W-1:0] idx);
    item_t it;
    it.mode       = mode;
    it.char_code  = ch;
    it.cell_index = idx;
    return it;
  endfunction

  // Mostly characters, with control codes common enough that the cursor reaches the
  // bottom row and scrolls often. Reads look at the whole grid and now and then past
  // its end. Clears are rare, since each one sends the cursor home again.
  function automatic item_t random_item();
    item_t it;
    int    r;
    it = make_item(MODE_PUT, CHAR_W'($urandom_range(0, 255)),
                   INDEX_W'($urandom_range(0, CELLS - 1)));
    r  = $urandom_range(0, 999);
    if (r < 700) begin
      r = $urandom_range(0, 99);
      if (r < 20) it.char_code = CODE_NEWLINE;
      else if (r < 28) it.char_code = CODE_BACKSPACE;
      else if (r < 36) it.char_code = CODE_TAB;
    end else if (r < 950) begin
      it.mode = MODE_READ;
      if ($urandom_range(0, 9) == 0)
        it.cell_index = INDEX_W'($urandom_range(CELLS, 2 ** INDEX_W - 1));
    end else if (r < 995) begin
      it.mode = MODE_SPARE;
    end else begin
      it.mode = MODE_CLEAR;
    end
    return it;
  endfunction

  // Offers one item and returns in the time step of the edge that took it. Valid is
  // left high so that back-to-back items never lower and raise it in one step; it only
  // drops when a gap is chosen or when the stimulus pauses.
  task automatic send_item(input item_t next);
    int gap;
    int r;
    if ($urandom_range(0, 99) == 0) sender_calm = !sender_calm;
    gap = 0;
    if (!sender_calm) begin
      r = $urandom_range(0, 99);
      if (r >= 92) gap = $urandom_range(10, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= next;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_ready !== 1'b1);
  endtask

  // Stops offering and waits until every predicted reply has come back. The count is
  // looked at on the falling edge, when the checker is done with the rising one.
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(negedge clk); while (replies_due != 0);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic write_color(input logic [COLOR_W-1:0] value);
    cfg_write_data <= value;
    cfg_write_en   <= 1'b1;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // Receiver side: calm stretches with ready always high alternate with stretches of
  // short and occasional long stalls. Once during the run it holds off for a long
  // while so that the block fills up and has to stop taking items.
  initial begin : reply_side
    int  stall_left;
    int  calm_left;
    int  r;
    bit  calm;
    bit  hold_done;
    stall_left = 0;
    calm_left  = 200;
    calm       = 1'b0;
    hold_done  = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      calm_left--;
      if (calm_left <= 0) begin
        calm      = !calm;
        calm_left = $urandom_range(100, 400);
      end
      if (hold_results && !hold_done) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        result_ready <= 1'b1;
      end else if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
        if (!calm) begin
          r = $urandom_range(0, 99);
          if (r >= 95) stall_left = $urandom_range(20, 60);
          else if (r >= 70) stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part in the reset color. The block runs its clearing pass first; the
    // handshake simply waits for it.
    send_item(make_item(MODE_READ, 8'h00, 11'd0));             // first cell after reset
    send_item(make_item(MODE_READ, 8'h00, INDEX_W'(CELLS - 1))); // last cell in the grid
    send_item(make_item(MODE_READ, 8'h00, INDEX_W'(CELLS)));   // first index past the end
    send_item(make_item(MODE_SPARE, 8'hFF, 11'h7FF));          // undefined mode, all ones
    send_item(make_item(MODE_PUT, CODE_BACKSPACE, 11'd0));     // backspace at column zero
    send_item(make_item(MODE_PUT, 8'hFF, 11'd0));              // highest character byte
    send_item(make_item(MODE_PUT, 8'h00, 11'd0));              // zero stored as a character
    send_item(make_item(MODE_PUT, 8'h41, 11'd0));
    send_item(make_item(MODE_PUT, CODE_BACKSPACE, 11'd0));     // backspace mid-line
    send_item(make_item(MODE_PUT, CODE_TAB, 11'd0));
    send_item(make_item(MODE_READ, 8'h00, 11'd0));
    send_item(make_item(MODE_READ, 8'h00, 11'd1));
    send_item(make_item(MODE_READ, 8'h00, 11'd2));
    send_item(make_item(MODE_PUT, 8'h7E, 11'd0));
    send_item(make_item(MODE_PUT, CODE_NEWLINE, 11'd0));       // blanks the rest of the row
    send_item(make_item(MODE_PUT, 8'h5A, 11'd0));
    send_item(make_item(MODE_READ, 8'h00, INDEX_W'(COLS)));    // start of the second row
    send_item(make_item(MODE_READ, 8'h00, 11'd6));             // the character written before the newline
    send_item(make_item(MODE_CLEAR, 8'h00, 11'd0));
    send_item(make_item(MODE_READ, 8'h00, INDEX_W'(COLS)));
    send_item(make_item(MODE_READ, 8'hFF, 11'h7FF));           // read with every index bit set

    // Random part in phases, with a new text color between phases: both extremes first,
    // then random values. The long receiver hold falls early in the second phase.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          write_color(8'hFF);
        end
        1: begin
          write_color(8'h00);
        end
        default: begin
          write_color(COLOR_W'($urandom_range(0, 255)));
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (phase == 1 && n == 50) hold_results = 1'b1;
        send_item(random_item());
      end
    end

    // Let the last replies come back, then give the block time to show anything extra.
    wait_drained();
    repeat (CELLS + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* text_console_writer.f */
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_sweep.sv
sv/text_console_writer.sv
bench/text_console_writer_checker.sv
bench/text_console_writer_tb.sv
